// ===== hdl/rbst_pkg.sv =====
// shared types and constants for the ray box slab test
// no dependencies
`default_nettype none
package rbst_pkg;
   localparam int NUM_AXES = 3;
   typedef enum logic [2:0] {
      REG_MIN_X = 3'd0,
      REG_MIN_Y = 3'd1,
      REG_MIN_Z = 3'd2,
      REG_MAX_X = 3'd3,
      REG_MAX_Y = 3'd4,
      REG_MAX_Z = 3'd5
   } reg_index_type;
endpackage
`default_nettype wire

// ===== hdl/rbst_div.sv =====
// pipelined signed fixed point divider, one quotient bit per stage
// depends on nothing; saturates like the slab test needs
`default_nettype none
module rbst_div #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         adv,
   input  wire logic signed [COORD_BITS:0]   num,
   input  wire logic signed [COORD_BITS-1:0] den,
   output logic signed [COORD_BITS-1:0]      quo
);
   localparam int NW = COORD_BITS + 1;
   localparam int QB = NW + FRAC_BITS;
   localparam int STG = QB;

   // magnitudes and flags
   logic [QB-1:0]       n_ff [STG+1];
   logic [COORD_BITS-1:0] d_ff [STG+1];
   logic [QB:0]         r_ff [STG+1];
   logic [QB-1:0]       q_ff [STG+1];
   logic                neg_ff [STG+1];
   logic                zd_ff [STG+1];
   logic                nn_ff [STG+1];

   // per stage shifted remainder and compare
   logic [QB:0]         rs [STG];
   logic                ge [STG];

   logic [NW-1:0] n_abs;
   logic [COORD_BITS-1:0] d_abs;
   assign n_abs = num[COORD_BITS] ? NW'(-num) : NW'(num);
   assign d_abs = den[COORD_BITS-1] ? COORD_BITS'(-den) : COORD_BITS'(den);

   always_comb begin
      for (int s = 0; s < STG; s++) begin
         rs[s] = {r_ff[s][QB-1:0], n_ff[s][QB-1-s]};
         ge[s] = rs[s] >= (QB+1)'(d_ff[s]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n_ff[0]   <= {n_abs, {FRAC_BITS{1'b0}}};
         d_ff[0]   <= d_abs;
         r_ff[0]   <= '0;
         q_ff[0]   <= '0;
         neg_ff[0] <= num[COORD_BITS] ^ den[COORD_BITS-1];
         zd_ff[0]  <= (den == '0);
         nn_ff[0]  <= num[COORD_BITS];
         for (int s = 0; s < STG; s++) begin
            n_ff[s+1]   <= n_ff[s];
            d_ff[s+1]   <= d_ff[s];
            r_ff[s+1]   <= ge[s] ? rs[s] - (QB+1)'(d_ff[s]) : rs[s];
            q_ff[s+1]   <= q_ff[s] | (QB'(ge[s]) << (QB-1-s));
            neg_ff[s+1] <= neg_ff[s];
            zd_ff[s+1]  <= zd_ff[s];
            nn_ff[s+1]  <= nn_ff[s];
         end
      end
   end

   localparam logic [QB-1:0] QMAXW = QB'({1'b0, {(COORD_BITS-1){1'b1}}});
   logic [QB-1:0] qf;
   assign qf = q_ff[STG];
   always_comb begin
      if (zd_ff[STG])
         quo = nn_ff[STG] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                          : {1'b0, {(COORD_BITS-1){1'b1}}};
      else if ((qf >> FRAC_BITS) > (QMAXW >> FRAC_BITS))
         quo = neg_ff[STG] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                           : {1'b0, {(COORD_BITS-1){1'b1}}};
      else if (neg_ff[STG])
         quo = COORD_BITS'(-qf);
      else
         quo = COORD_BITS'(qf);
   end
endmodule
`default_nettype wire

// ===== hdl/rbst_front.sv =====
// front: accepts rays, forms the six face distances, feeds a two entry queue
// depends on rbst_pkg
`default_nettype none
module rbst_front import rbst_pkg::*; #(
   parameter int COORD_BITS = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic signed [COORD_BITS-1:0] box_lo [NUM_AXES],
   input  wire logic signed [COORD_BITS-1:0] box_hi [NUM_AXES],
   input  wire logic signed [COORD_BITS-1:0] org [NUM_AXES],
   input  wire logic signed [COORD_BITS-1:0] dir [NUM_AXES],
   output logic                              q_valid,
   input  wire logic                         q_pop,
   output logic signed [COORD_BITS:0]        q_n1 [NUM_AXES],
   output logic signed [COORD_BITS:0]        q_n2 [NUM_AXES],
   output logic signed [COORD_BITS-1:0]      q_d [NUM_AXES]
);
   logic signed [COORD_BITS:0]   n1_ff [2][NUM_AXES];
   logic signed [COORD_BITS:0]   n2_ff [2][NUM_AXES];
   logic signed [COORD_BITS-1:0] d_ff [2][NUM_AXES];
   logic [1:0] cnt_ff;
   logic       wp_ff, rp_ff;
   logic       push;

   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_n1 = n1_ff[rp_ff];
   assign q_n2 = n2_ff[rp_ff];
   assign q_d  = d_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_ff + 2'(push) - 2'(q_pop);
         if (push) wp_ff <= !wp_ff;
         if (q_pop) rp_ff <= !rp_ff;
      end
      if (push) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            n1_ff[wp_ff][a] <= (COORD_BITS+1)'(box_lo[a]) - (COORD_BITS+1)'(org[a]);
            n2_ff[wp_ff][a] <= (COORD_BITS+1)'(box_hi[a]) - (COORD_BITS+1)'(org[a]);
            d_ff[wp_ff][a]  <= dir[a];
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !q_pop) |=> !in_ready)
      else $error("full queue took an item");
endmodule
`default_nettype wire

// ===== hdl/rbst_back.sv =====
// back: six pipelined dividers, min/max reduction, output register
// depends on rbst_pkg and rbst_div
`default_nettype none
module rbst_back import rbst_pkg::*; #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         q_valid,
   output logic                              q_pop,
   input  wire logic signed [COORD_BITS:0]   q_n1 [NUM_AXES],
   input  wire logic signed [COORD_BITS:0]   q_n2 [NUM_AXES],
   input  wire logic signed [COORD_BITS-1:0] q_d [NUM_AXES],
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic                              out_hit
);
   localparam int LAT = COORD_BITS + 1 + FRAC_BITS + 1;

   logic                   adv;
   logic [LAT-1:0]         vld_ff;
   logic signed [COORD_BITS-1:0] t1 [NUM_AXES];
   logic signed [COORD_BITS-1:0] t2 [NUM_AXES];
   logic signed [COORD_BITS-1:0] lo_ff [NUM_AXES];
   logic signed [COORD_BITS-1:0] hi_ff [NUM_AXES];
   logic                   rv_ff;
   logic signed [COORD_BITS-1:0] near_t, far_t;
   logic                   ov_ff, oh_ff;

   // pipe stalls as one when its tail result cannot move on
   assign adv = !(rv_ff && out_valid && !out_ready);
   assign q_pop = adv && q_valid;

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      rbst_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_d1 (
         .clock(clock), .adv(adv), .num(q_n1[a]), .den(q_d[a]), .quo(t1[a]));
      rbst_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_d2 (
         .clock(clock), .adv(adv), .num(q_n2[a]), .den(q_d[a]), .quo(t2[a]));
   end

   always_comb begin
      near_t = (lo_ff[0] > lo_ff[1]) ? lo_ff[0] : lo_ff[1];
      near_t = (lo_ff[2] > near_t) ? lo_ff[2] : near_t;
      far_t  = (hi_ff[0] < hi_ff[1]) ? hi_ff[0] : hi_ff[1];
      far_t  = (hi_ff[2] < far_t) ? hi_ff[2] : far_t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rv_ff  <= 1'b0;
         ov_ff  <= 1'b0;
      end else begin
         if (adv) begin
            vld_ff <= {vld_ff[LAT-2:0], q_valid};
            rv_ff  <= vld_ff[LAT-1];
         end
         if (adv && rv_ff) ov_ff <= 1'b1;
         else if (out_ready) ov_ff <= 1'b0;
      end
      if (adv) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            lo_ff[a] <= (t1[a] < t2[a]) ? t1[a] : t2[a];
            hi_ff[a] <= (t1[a] < t2[a]) ? t2[a] : t1[a];
         end
         if (rv_ff) oh_ff <= !far_t[COORD_BITS-1] && (near_t < far_t);
      end
   end

   assign out_valid = ov_ff;
   assign out_hit   = oh_ff;

   assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid)
      else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready && rv_ff) |-> !adv)
      else $error("pipe moved over a held result");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> $stable(out_hit))
      else $error("held result changed");
endmodule
`default_nettype wire

// ===== hdl/ray_box_slab_test.sv =====
// ray against axis-aligned box slab test, top level
// depends on rbst_pkg, rbst_front, rbst_back, rbst_div
// path: front queue, divider stages, min/max registers, output register (Q16.16 by default)
// throughput: one item per cycle while no result is held, set by the fully pipelined restoring dividers
// reset: synchronous, clears queue and valid flags; box registers reset to zero
`default_nettype none
module ray_box_slab_test import rbst_pkg::*; #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write_enable,
   input  wire logic [2:0]                   csr_index,
   input  wire logic [COORD_BITS-1:0]        csr_write_data,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [COORD_BITS-1:0] req_origin_x,
   input  wire logic signed [COORD_BITS-1:0] req_origin_y,
   input  wire logic signed [COORD_BITS-1:0] req_origin_z,
   input  wire logic signed [COORD_BITS-1:0] req_dir_x,
   input  wire logic signed [COORD_BITS-1:0] req_dir_y,
   input  wire logic signed [COORD_BITS-1:0] req_dir_z,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_hit
);
   // box corner registers
   logic signed [COORD_BITS-1:0] lo_ff [NUM_AXES];
   logic signed [COORD_BITS-1:0] hi_ff [NUM_AXES];
   logic signed [COORD_BITS-1:0] org [NUM_AXES];
   logic signed [COORD_BITS-1:0] dir [NUM_AXES];
   logic signed [COORD_BITS:0]   q_n1 [NUM_AXES];
   logic signed [COORD_BITS:0]   q_n2 [NUM_AXES];
   logic signed [COORD_BITS-1:0] q_d [NUM_AXES];
   logic q_valid, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            lo_ff[a] <= '0;
            hi_ff[a] <= '0;
         end
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_MIN_X: lo_ff[0] <= csr_write_data;
            REG_MIN_Y: lo_ff[1] <= csr_write_data;
            REG_MIN_Z: lo_ff[2] <= csr_write_data;
            REG_MAX_X: hi_ff[0] <= csr_write_data;
            REG_MAX_Y: hi_ff[1] <= csr_write_data;
            REG_MAX_Z: hi_ff[2] <= csr_write_data;
            default: ;  // unknown index ignored
         endcase
      end
   end

   assign org = '{req_origin_x, req_origin_y, req_origin_z};
   assign dir = '{req_dir_x, req_dir_y, req_dir_z};

   // front: face distances into a short queue
   rbst_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_ready(req_ready),
      .box_lo(lo_ff), .box_hi(hi_ff), .org(org), .dir(dir),
      .q_valid(q_valid), .q_pop(q_pop), .q_n1(q_n1), .q_n2(q_n2), .q_d(q_d));

   // back: division, slab reduction, result register
   rbst_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_pop(q_pop),
      .q_n1(q_n1), .q_n2(q_n2), .q_d(q_d),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_hit(rsp_hit));

   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("back popped an empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result lost under stall");
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> q_valid)
      else $error("accepted item missing from queue");
endmodule
`default_nettype wire
